// ===== rtl/mmc_pkg.sv =====
// Package for the model matrix composer: widths, CORDIC constants, helpers.
// No dependencies.
package mmc_pkg;
    localparam int CordicStages = 16;
    localparam int FracBits     = 16;
    localparam int AngW         = 16;
    localparam int ZW           = 36;
    localparam int TrigW        = FracBits + 3;
    localparam int ProdW        = 2 * TrigW;
    localparam int DegFull      = 23040;
    localparam int DegHalf      = 11520;
    localparam int DegQuarter   = 5760;
    localparam int DataW        = 32;
    localparam int InW          = 9 * 32 - 3 * 16;
    localparam int OutW         = 2 + 4 * 32;

    localparam logic signed [ZW-1:0] AtanDeg24 [24] = '{
        36'sd754974720, 36'sd445687602, 36'sd235489088, 36'sd119537938,
        36'sd60000934, 36'sd30029717, 36'sd15018523, 36'sd7509720,
        36'sd3754917, 36'sd1877466, 36'sd938734, 36'sd469367,
        36'sd234684, 36'sd117342, 36'sd58671, 36'sd29335,
        36'sd14668, 36'sd7334, 36'sd3667, 36'sd1833,
        36'sd917, 36'sd458, 36'sd229, 36'sd115
    };

    localparam logic signed [TrigW-1:0] CordicGain =
        TrigW'((64'sd652032875 + (64'sd1 <<< (29 - FracBits))) >>> (30 - FracBits));
    localparam logic signed [TrigW-1:0] TrigOne = TrigW'(1) <<< FracBits;

    // one CORDIC lane word
    typedef struct packed {
        logic signed [TrigW+1:0] x;
        logic signed [TrigW+1:0] y;
        logic signed [ZW-1:0]    z;
        logic                    flip;
    } cordic_word_t;

    typedef struct packed {
        logic signed [TrigW-1:0] c;
        logic signed [TrigW-1:0] s;
    } trig_t;

    // product rounded half up back to FracBits
    function automatic logic signed [TrigW+1:0] fmul(input logic signed [TrigW+1:0] a,
                                                      input logic signed [TrigW+1:0] b);
        logic signed [2*TrigW+3:0] p;
        p = a * b + (2*TrigW+4)'(1 <<< (FracBits - 1));
        return (TrigW+2)'(p >>> FracBits);
    endfunction
endpackage

// ===== rtl/mmc_cordic_cell.sv =====
// One CORDIC micro-rotation cell; stage number selects shift and arctangent.
// Depends on mmc_pkg.
module mmc_cordic_cell (
    input  logic                 aclk,
    input  logic                 en,
    input  logic [4:0]           stage,
    input  mmc_pkg::cordic_word_t w_in,
    output mmc_pkg::cordic_word_t w_out
);
    import mmc_pkg::*;
    cordic_word_t w_reg, w_next;

    always_comb begin
        w_next = w_in;
        if (!w_in.z[ZW-1]) begin
            w_next.x = w_in.x - (w_in.y >>> stage);
            w_next.y = w_in.y + (w_in.x >>> stage);
            w_next.z = w_in.z - AtanDeg24[stage];
        end else begin
            w_next.x = w_in.x + (w_in.y >>> stage);
            w_next.y = w_in.y - (w_in.x >>> stage);
            w_next.z = w_in.z + AtanDeg24[stage];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) w_reg <= w_next;
    end
    assign w_out = w_reg;
endmodule

// ===== rtl/mmc_cordic_chain.sv =====
// Angle reduction and a chain of CORDIC cells giving clamped cosine and sine.
// Depends on mmc_pkg and mmc_cordic_cell.
module mmc_cordic_chain (
    input  logic                        aclk,
    input  logic                        en,
    input  logic signed [mmc_pkg::AngW-1:0] ang,
    output mmc_pkg::trig_t              trig
);
    import mmc_pkg::*;
    cordic_word_t w [CordicStages+1];
    cordic_word_t w0_reg, w0_next;
    trig_t        trig_reg, trig_next;
    logic signed [16:0] m_rem;
    logic signed [15:0] m_red;
    logic               flip;

    always_comb begin
        // fold into one turn; the input spans less than two turns either way
        m_rem = 17'(ang);
        if (m_rem >= 17'(DegFull)) m_rem = m_rem - 17'(DegFull);
        else if (m_rem < -17'(DegFull)) m_rem = m_rem + 17'(2 * DegFull);
        else if (m_rem < 0) m_rem = m_rem + 17'(DegFull);
        if (m_rem >= 17'(DegHalf)) m_rem = m_rem - 17'(DegFull);
        m_red = 16'(m_rem);
        flip  = 1'b0;
        if (m_rem > 17'(DegQuarter)) begin
            m_red = 16'(m_rem - 17'(DegHalf));
            flip  = 1'b1;
        end else if (m_rem < -17'(DegQuarter)) begin
            m_red = 16'(m_rem + 17'(DegHalf));
            flip  = 1'b1;
        end
        w0_next.x    = (TrigW+2)'(CordicGain);
        w0_next.y    = '0;
        w0_next.z    = ZW'(m_red) <<< 18;
        w0_next.flip = flip;
    end

    always_ff @(posedge aclk) begin
        if (en) w0_reg <= w0_next;
    end
    assign w[0] = w0_reg;

    for (genvar i = 0; i < CordicStages; i++) begin : g_cell
        mmc_cordic_cell u_cell (
            .aclk(aclk), .en(en), .stage(5'(i)), .w_in(w[i]), .w_out(w[i+1])
        );
    end

    always_comb begin
        logic signed [TrigW+1:0] x, y;
        x = w[CordicStages].x;
        y = w[CordicStages].y;
        if (x > TrigOne) x = TrigOne;
        if (x < -TrigOne) x = -TrigOne;
        if (y > TrigOne) y = TrigOne;
        if (y < -TrigOne) y = -TrigOne;
        if (w[CordicStages].flip) begin
            x = -x;
            y = -y;
        end
        trig_next.c = TrigW'(x);
        trig_next.s = TrigW'(y);
    end

    always_ff @(posedge aclk) begin
        if (en) trig_reg <= trig_next;
    end
    assign trig = trig_reg;
endmodule

// ===== rtl/model_matrix_compose.sv =====
// Top level of the model matrix composer: three CORDIC chains, rotation
// product pipeline and row serialiser. Depends on mmc_pkg, mmc_cordic_chain.
//
// Usage: s_axis carries one transform word (position, Euler degrees, scale).
// m_axis returns four words, rows 0..3 of S*Rx*Ry*Rz*T, tlast on row 3,
// tuser = saturation flag of that row.
// The pipeline advances as one whole whenever its output slot is free or its
// last stage is empty, so a new word enters each cycle the pipe moves; the output
// serialiser takes a matrix and emits one row per cycle while m_axis_tready is high.
// Reset clears the valid bits and the row counter only; nothing is in flight afterwards and
// s_axis_tready stays low while reset is held.
// When m_axis_tready is low the rows hold and the pipeline stalls behind
// them; s_axis_tready drops until a slot opens.
// Matrix products use 21x21 multipliers, one product rank per stage, then
// 32x21 scale multipliers in the last stage.
module model_matrix_compose (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // pos_x, pos_y, pos_z, rot_x_deg, rot_y_deg, rot_z_deg, scale_x, scale_y, scale_z
    input  logic [mmc_pkg::InW-1:0]  s_axis_tdata,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // row_index, col0, col1, col2, col3, zero pad
    output logic [135:0]             m_axis_tdata,
    output logic                     m_axis_tlast,
    // saturated
    output logic                     m_axis_tuser
);
    import mmc_pkg::*;
    localparam int Depth = CordicStages + 4;
    localparam int SW    = TrigW + 2;

    logic en;
    logic [Depth-1:0] vld_reg;
    trig_t tx, ty, tz;
    logic [95:0] pos_pipe_reg [Depth];
    logic [95:0] scl_pipe_reg [Depth];

    // four-row matrix buffer and row counter
    logic        buf_vld_reg;
    logic [1:0]  row_reg;
    logic signed [31:0] e_reg [3][3];
    logic [2:0]  sat_reg;
    logic [95:0] pos_reg;

    logic buf_free;
    assign buf_free = !buf_vld_reg || (m_axis_tready && row_reg == 2'd3);
    assign en = buf_free || !vld_reg[Depth-1];
    assign s_axis_tready = en && aresetn;

    mmc_cordic_chain u_cx (.aclk(aclk), .en(en), .ang(s_axis_tdata[111:96]), .trig(tx));
    mmc_cordic_chain u_cy (.aclk(aclk), .en(en), .ang(s_axis_tdata[127:112]), .trig(ty));
    mmc_cordic_chain u_cz (.aclk(aclk), .en(en), .ang(s_axis_tdata[143:128]), .trig(tz));

    always_ff @(posedge aclk) begin
        if (!aresetn) vld_reg <= '0;
        else if (en) vld_reg <= {vld_reg[Depth-2:0], s_axis_tvalid};
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            pos_pipe_reg[0] <= s_axis_tdata[95:0];
            scl_pipe_reg[0] <= s_axis_tdata[239:144];
            for (int i = 1; i < Depth; i++) begin
                pos_pipe_reg[i] <= pos_pipe_reg[i-1];
                scl_pipe_reg[i] <= scl_pipe_reg[i-1];
            end
        end
    end

    // trig arrives at stage Depth-3; form pair products, then triples
    logic signed [SW-1:0] cx, sx, cy, sy, cz, sz;
    assign cx = SW'(tx.c); assign sx = SW'(tx.s);
    assign cy = SW'(ty.c); assign sy = SW'(ty.s);
    assign cz = SW'(tz.c); assign sz = SW'(tz.s);

    logic signed [SW-1:0] p1_reg [10];
    logic signed [SW-1:0] r_reg [3];
    always_ff @(posedge aclk) begin
        if (en) begin
            p1_reg[0] <= fmul(cy, cz);
            p1_reg[1] <= fmul(cy, sz);
            p1_reg[2] <= -sy;
            p1_reg[3] <= fmul(sx, sy);
            p1_reg[4] <= fmul(cx, sy);
            p1_reg[5] <= fmul(cx, sz);
            p1_reg[6] <= fmul(cx, cz);
            p1_reg[7] <= fmul(sx, cy);
            p1_reg[8] <= fmul(sx, sz);
            p1_reg[9] <= fmul(cx, cy);
            // hold cz, sz, sx beside them
            r_reg[0] <= cz; r_reg[1] <= sz; r_reg[2] <= sx;
        end
    end

    logic signed [SW-1:0] r2_reg [3][3];
    always_ff @(posedge aclk) begin
        if (en) begin
            r2_reg[0][0] <= p1_reg[0];
            r2_reg[0][1] <= p1_reg[1];
            r2_reg[0][2] <= p1_reg[2];
            r2_reg[1][0] <= fmul(p1_reg[3], r_reg[0]) - p1_reg[5];
            r2_reg[1][1] <= fmul(p1_reg[3], r_reg[1]) + p1_reg[6];
            r2_reg[1][2] <= p1_reg[7];
            r2_reg[2][0] <= fmul(p1_reg[4], r_reg[0]) + p1_reg[8];
            r2_reg[2][1] <= fmul(p1_reg[4], r_reg[1]) - fmul(r_reg[2], r_reg[0]);
            r2_reg[2][2] <= p1_reg[9];
        end
    end

    // scale stage: result into matrix buffer
    logic [95:0] scl_now, pos_now;
    assign scl_now = scl_pipe_reg[Depth-1];
    assign pos_now = pos_pipe_reg[Depth-1];
    logic signed [31:0] e_next [3][3];
    logic [2:0] sat_next;
    always_comb begin
        logic signed [63:0] p;
        logic signed [31:0] sc;
        for (int k = 0; k < 3; k++) begin
            sat_next[k] = 1'b0;
            sc = scl_now[32*k +: 32];
            for (int j = 0; j < 3; j++) begin
                p = (64'(sc) * 64'(r2_reg[k][j]) + 64'(1 <<< (FracBits - 1))) >>> FracBits;
                if (p > 64'sd2147483647) begin
                    e_next[k][j] = 32'h7FFFFFFF;
                    sat_next[k] = 1'b1;
                end else if (p < -64'sd2147483648) begin
                    e_next[k][j] = 32'h80000000;
                    sat_next[k] = 1'b1;
                end else begin
                    e_next[k][j] = 32'(p);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_vld_reg <= 1'b0;
            row_reg     <= '0;
        end else if (buf_free) begin
            buf_vld_reg <= vld_reg[Depth-1];
            row_reg     <= '0;
        end else if (m_axis_tready) begin
            row_reg <= row_reg + 2'd1;
        end
    end
    always_ff @(posedge aclk) begin
        if (buf_free) begin
            e_reg   <= e_next;
            sat_reg <= sat_next;
            pos_reg <= pos_now;
        end
    end

    always_comb begin
        m_axis_tvalid = buf_vld_reg;
        m_axis_tlast  = (row_reg == 2'd3);
        m_axis_tdata  = '0;
        m_axis_tdata[1:0] = row_reg;
        if (row_reg == 2'd3) begin
            m_axis_tdata[97:2]    = pos_reg;
            m_axis_tdata[129:98]  = 32'd65536;
            m_axis_tuser          = 1'b0;
        end else begin
            m_axis_tdata[33:2]   = e_reg[row_reg][0];
            m_axis_tdata[65:34]  = e_reg[row_reg][1];
            m_axis_tdata[97:66]  = e_reg[row_reg][2];
            m_axis_tuser         = sat_reg[row_reg];
        end
    end
endmodule

// ===== dv/tb.sv =====
// Self-checking bench for model_matrix_compose: directed and random transform
// words, four predicted matrix rows per word. Depends on mmc_pkg and the RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  Q6Deg      = 64;
    localparam int  CycleLimit = 400000;
    localparam int  DrainWait  = 60;
    localparam longint OneQ    = 64'sd1 <<< mmc_pkg::FracBits;

    typedef struct {
        logic signed [31:0] px, py, pz;
        logic signed [15:0] rx, ry, rz;
        logic signed [31:0] kx, ky, kz;
    } xform_t;

    typedef struct packed {
        logic [1:0]  idx;
        logic [31:0] c0, c1, c2, c3;
        logic        last;
        logic        sat;
    } mrow_t;

    logic         aclk;
    logic         aresetn;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [mmc_pkg::InW-1:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [135:0] m_axis_tdata;
    logic         m_axis_tlast;
    logic         m_axis_tuser;

    mrow_t  rows_due[$];
    xform_t dir_tab[$];
    int     send_idle_pct;
    int     recv_stall_pct;
    int     n_bad = 0;
    int     n_rows = 0;
    int     n_sat = 0;
    int     n_words = 0;
    int     cycles = 0;

    model_matrix_compose u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic longint qmul(input longint a, input longint b);
        return (a * b + (64'sd1 <<< (mmc_pkg::FracBits - 1))) >>> mmc_pkg::FracBits;
    endfunction

    // CORDIC sine and cosine of a Q10.6 degree angle
    task automatic trig_deg(input longint ang, output longint c, output longint s);
        longint m, x, y, z, nx;
        bit flip;
        flip = 1'b0;
        m = ang % mmc_pkg::DegFull;
        if (m < 0) m += mmc_pkg::DegFull;
        if (m >= mmc_pkg::DegHalf) m -= mmc_pkg::DegFull;
        if (m > mmc_pkg::DegQuarter) begin
            m -= mmc_pkg::DegHalf;
            flip = 1'b1;
        end else if (m < -mmc_pkg::DegQuarter) begin
            m += mmc_pkg::DegHalf;
            flip = 1'b1;
        end
        x = (64'sd652032875 + (64'sd1 <<< (29 - mmc_pkg::FracBits)))
            >>> (30 - mmc_pkg::FracBits);
        y = 0;
        z = m * 262144;
        for (int i = 0; i < mmc_pkg::CordicStages; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z -= longint'(mmc_pkg::AtanDeg24[i]);
            end else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z += longint'(mmc_pkg::AtanDeg24[i]);
            end
            x = nx;
        end
        if (x > OneQ) x = OneQ;
        if (x < -OneQ) x = -OneQ;
        if (y > OneQ) y = OneQ;
        if (y < -OneQ) y = -OneQ;
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    // queue the four rows of S*Rx*Ry*Rz*T for one transform word
    task automatic compose_rows(input xform_t t);
        longint cx, sx, cy, sy, cz, sz, e;
        longint r[3][3];
        longint k[3];
        longint el[3];
        mrow_t  w;
        trig_deg(longint'(t.rx), cx, sx);
        trig_deg(longint'(t.ry), cy, sy);
        trig_deg(longint'(t.rz), cz, sz);
        k[0] = t.kx;
        k[1] = t.ky;
        k[2] = t.kz;
        r[0][0] = qmul(cy, cz);
        r[0][1] = qmul(cy, sz);
        r[0][2] = -sy;
        r[1][0] = qmul(qmul(sx, sy), cz) - qmul(cx, sz);
        r[1][1] = qmul(qmul(sx, sy), sz) + qmul(cx, cz);
        r[1][2] = qmul(sx, cy);
        r[2][0] = qmul(qmul(cx, sy), cz) + qmul(sx, sz);
        r[2][1] = qmul(qmul(cx, sy), sz) - qmul(sx, cz);
        r[2][2] = qmul(cx, cy);
        for (int i = 0; i < 3; i++) begin
            w.sat = 1'b0;
            for (int j = 0; j < 3; j++) begin
                e = qmul(k[i], r[i][j]);
                if (e > 64'sd2147483647) begin
                    e = 64'sd2147483647;
                    w.sat = 1'b1;
                end
                if (e < -64'sd2147483648) begin
                    e = -64'sd2147483648;
                    w.sat = 1'b1;
                end
                el[j] = e;
            end
            w.idx  = 2'(i);
            w.c0   = el[0][31:0];
            w.c1   = el[1][31:0];
            w.c2   = el[2][31:0];
            w.c3   = '0;
            w.last = 1'b0;
            rows_due.push_back(w);
        end
        // translation row is a plain copy
        w = '{idx: 2'd3, c0: t.px, c1: t.py, c2: t.pz, c3: 32'h0001_0000,
              last: 1'b1, sat: 1'b0};
        rows_due.push_back(w);
    endtask

    function automatic xform_t mk(input int px, input int py, input int pz,
                                  input int rx, input int ry, input int rz,
                                  input int kx, input int ky, input int kz);
        xform_t t;
        t = '{px: px, py: py, pz: pz, rx: 16'(rx), ry: 16'(ry), rz: 16'(rz),
              kx: kx, ky: ky, kz: kz};
        return t;
    endfunction

    function automatic int rnd_angle();
        case ($urandom_range(3))
            0: return $urandom_range(2 * 90 * Q6Deg) - 90 * Q6Deg;
            1: return $urandom_range(2 * 360 * Q6Deg) - 360 * Q6Deg;
            2: return 90 * Q6Deg * ($urandom_range(8) - 4) + $urandom_range(4) - 2;
            default: return int'($signed(16'($urandom())));
        endcase
    endfunction

    function automatic int rnd_scale();
        case ($urandom_range(3))
            0, 1: return $urandom_range(32'h0008_0000) - 32'h0004_0000;
            2: return $urandom_range(1) ? 32'h7fff_ffff - $urandom_range(255)
                                         : 32'h8000_0000 + $urandom_range(255);
            default: return $urandom();
        endcase
    endfunction

    task automatic send_word(input xform_t t);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_axis_tdata  = {t.kz, t.ky, t.kx, t.rz, t.ry, t.rx, t.pz, t.py, t.px};
        s_axis_tvalid = 1'b1;
        do @(posedge aclk); while (!s_axis_tready);
        compose_rows(t);
        n_words++;
    endtask

    task automatic drain();
        @(negedge aclk);
        s_axis_tvalid = 1'b0;
        while (rows_due.size() != 0) @(posedge aclk);
    endtask

    // receiver back-pressure
    always @(negedge aclk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        mrow_t  w;
        mrow_t  got;
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("timeout after %0d cycles, %0d rows outstanding", cycles,
                     rows_due.size());
            $display("== FAIL ==");
            $finish;
        end else if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = '{idx: m_axis_tdata[1:0], c0: m_axis_tdata[33:2],
                    c1: m_axis_tdata[65:34], c2: m_axis_tdata[97:66],
                    c3: m_axis_tdata[129:98], last: m_axis_tlast, sat: m_axis_tuser};
            n_rows++;
            if (got.sat) n_sat++;
            if (rows_due.size() == 0) begin
                n_bad++;
                if (n_bad <= 10) $display("unexpected row word %p", got);
            end else begin
                w = rows_due.pop_front();
                if (got !== w) begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("row mismatch: expected %p got %p", w, got);
                end
            end
        end
    end

    initial begin
        xform_t t;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        aresetn        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // identity, quadrants, wrap-around, extremes of every field
        dir_tab.push_back(mk(0, 0, 0, 0, 0, 0, 32'h10000, 32'h10000, 32'h10000));
        dir_tab.push_back(mk(32'h7fffffff, 32'h80000000, -1, 0, 0, 0, 1, -1, 0));
        dir_tab.push_back(mk(1, 2, 3, 90 * Q6Deg, 0, 0, 32'h10000, 32'h10000, 32'h10000));
        dir_tab.push_back(mk(0, 0, 0, 0, -90 * Q6Deg, 0, 32'h10000, 32'h10000, 32'h10000));
        dir_tab.push_back(mk(0, 0, 0, 0, 0, 90 * Q6Deg + 1, 32'h10000, 32'h10000, 32'h10000));
        dir_tab.push_back(mk(0, 0, 0, 180 * Q6Deg, -180 * Q6Deg, 179 * Q6Deg,
                             32'h10000, 32'h10000, 32'h10000));
        dir_tab.push_back(mk(0, 0, 0, -90 * Q6Deg - 1, 270 * Q6Deg, 360 * Q6Deg,
                             32'h10000, 32'h10000, 32'h10000));
        dir_tab.push_back(mk(0, 0, 0, 32767, -32768, 32767,
                             32'h10000, 32'h10000, 32'h10000));
        dir_tab.push_back(mk(0, 0, 0, 45 * Q6Deg, 45 * Q6Deg, 45 * Q6Deg,
                             32'h7fffffff, 32'h80000000, 32'h7fffffff));
        dir_tab.push_back(mk(0, 0, 0, 0, 0, 0, 32'h7fffffff, 32'h80000000, 32'h80000000));
        dir_tab.push_back(mk(0, 0, 0, -45 * Q6Deg, 30 * Q6Deg, -60 * Q6Deg,
                             32'h80000000, 32'h7fffffff, 0));
        dir_tab.push_back(mk(-1, 32'h7fffffff, 32'h80000000, 1, -1, 0, -1, 1, 32'hffff0000));
        dir_tab.push_back(mk(5, 6, 7, 30 * Q6Deg, 60 * Q6Deg, 120 * Q6Deg,
                             32'h20000, 32'hfffe0000, 32'h8000));
        foreach (dir_tab[i]) send_word(dir_tab[i]);
        drain();

        // random words across four idling regimes
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1 || ph == 3) ? (ph == 3 ? 33 : 46) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 3 ? 33 : 46) : 0;
            for (int n = 0; n < 62; n++) begin
                t = mk($urandom(), $urandom(), $urandom(), rnd_angle(), rnd_angle(),
                       rnd_angle(), rnd_scale(), rnd_scale(), rnd_scale());
                send_word(t);
                // let the pipe run dry once mid-phase
                if (n == 30) drain();
            end
            drain();
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (DrainWait) @(posedge aclk);

        $display("%0d transform words, %0d rows checked (%0d saturated), %0d mismatches",
                 n_words, n_rows, n_sat, n_bad);
        $display("quadrant and wrap angles, clamped scales, four stall regimes covered");
        if (n_bad == 0 && rows_due.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/mmc_pkg.sv
rtl/mmc_cordic_cell.sv
rtl/mmc_cordic_chain.sv
rtl/model_matrix_compose.sv
dv/tb.sv
